// ===== rtl/core/iva_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and helper functions for the integer 3-vector alu
package iva_pkg;

   // fixed-point and datapath widths
   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int OPND_W    = WORD_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int QUOT_W    = NUM_W - FRAC_BITS;

   // 1.0 in the weight format, wide enough for an exact one minus weight
   localparam logic signed [OPND_W-1:0] ONE_FX = OPND_W'(1 << FRAC_BITS);

   localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // operation codes
   typedef enum logic [3:0] {
      ACT_ADD    = 4'd0,
      ACT_SUB    = 4'd1,
      ACT_MIN    = 4'd2,
      ACT_MAX    = 4'd3,
      ACT_DOT    = 4'd4,
      ACT_CROSS  = 4'd5,
      ACT_SCALE  = 4'd6,
      ACT_LERP   = 4'd7,
      ACT_INTERP = 4'd8
   } action_type;

   // request payload
   typedef struct packed {
      logic [3:0]               action;
      logic signed [WORD_W-1:0] ax;
      logic signed [WORD_W-1:0] ay;
      logic signed [WORD_W-1:0] az;
      logic signed [WORD_W-1:0] bx;
      logic signed [WORD_W-1:0] by;
      logic signed [WORD_W-1:0] bz;
      logic signed [WORD_W-1:0] weight;
   } req_type;

   // response payload
   typedef struct packed {
      logic signed [WORD_W-1:0] rx;
      logic signed [WORD_W-1:0] ry;
      logic signed [WORD_W-1:0] rz;
      logic signed [WORD_W-1:0] scalar;
   } rsp_type;

   // decoded operation flags that travel down the pipeline
   typedef struct packed {
      logic is_add;
      logic is_sub;
      logic is_min;
      logic is_max;
      logic is_dot;
      logic is_cross;
      logic is_scale;
      logic is_lerp;
      logic is_interp;
   } ctrl_type;

   // unused codes decode to no operation at all
   function automatic ctrl_type decode_action(input logic [3:0] action);
      ctrl_type c;
      c = '0;
      case (action)
         ACT_ADD:    c.is_add    = 1'b1;
         ACT_SUB:    c.is_sub    = 1'b1;
         ACT_MIN:    c.is_min    = 1'b1;
         ACT_MAX:    c.is_max    = 1'b1;
         ACT_DOT:    c.is_dot    = 1'b1;
         ACT_CROSS:  c.is_cross  = 1'b1;
         ACT_SCALE:  c.is_scale  = 1'b1;
         ACT_LERP:   c.is_lerp   = 1'b1;
         ACT_INTERP: c.is_interp = 1'b1;
         default:    c = '0;
      endcase
      return c;
   endfunction

   // divide by 2^FRAC_BITS rounding toward zero
   function automatic logic signed [QUOT_W-1:0] trunc_div(input logic signed [NUM_W-1:0] n);
      logic signed [NUM_W-1:0] fl;
      logic                    bump;
      fl   = n >>> FRAC_BITS;
      bump = n[NUM_W-1] && (|n[FRAC_BITS-1:0]);
      return QUOT_W'(fl) + QUOT_W'(bump);
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic [WORD_W-1:0] sat_word(input logic signed [QUOT_W-1:0] q);
      logic fits;
      fits = (&q[QUOT_W-1:WORD_W-1]) || !(|q[QUOT_W-1:WORD_W-1]);
      if (fits) begin
         return q[WORD_W-1:0];
      end else if (q[QUOT_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

endpackage

// ===== rtl/core/iva_lane.sv =====
`timescale 1ns / 1ps
// one component lane: operand select, two multipliers, truncation and saturation
module iva_lane (
   input  logic                                clock,
   input  iva_pkg::ctrl_type                   ctrl,
   input  logic signed [iva_pkg::WORD_W-1:0]   a,
   input  logic signed [iva_pkg::WORD_W-1:0]   b,
   input  logic signed [iva_pkg::WORD_W-1:0]   w,
   input  logic signed [iva_pkg::WORD_W-1:0]   cross_a0,
   input  logic signed [iva_pkg::WORD_W-1:0]   cross_b0,
   input  logic signed [iva_pkg::WORD_W-1:0]   cross_a1,
   input  logic signed [iva_pkg::WORD_W-1:0]   cross_b1,
   output logic        [iva_pkg::WORD_W-1:0]   dot_lo,
   output logic        [iva_pkg::WORD_W-1:0]   result
);

   localparam int WW = iva_pkg::WORD_W;
   localparam int OW = iva_pkg::OPND_W;
   localparam int PW = iva_pkg::PROD_W;
   localparam int NW = iva_pkg::NUM_W;
   localparam int QW = iva_pkg::QUOT_W;

   // stage 2 registers
   logic signed [OW-1:0] m0a_in, m0b_in, m1a_in, m1b_in;
   logic signed [OW-1:0] m0a_ff, m0b_ff, m1a_ff, m1b_ff;
   logic        [WW-1:0] direct2_in, direct2_ff;
   logic signed [WW-1:0] a2_ff;
   iva_pkg::ctrl_type    ctrl2_ff;

   // stage 3 registers
   logic signed [PW-1:0] p0_in, p1_in, p0_ff, p1_ff;
   logic        [WW-1:0] direct3_ff;
   logic signed [WW-1:0] a3_ff;
   iva_pkg::ctrl_type    ctrl3_ff;

   // stage 4 registers
   logic signed [NW-1:0] lerp_off;
   logic signed [NW-1:0] n0_in, n1_in, n0_ff, n1_ff;
   logic        [WW-1:0] direct4_in, direct4_ff;
   logic        [WW-1:0] dot_lo_ff;
   iva_pkg::ctrl_type    ctrl4_ff;

   // stage 5 registers
   logic signed [QW-1:0] q0_in, q1_in, q0_ff, q1_ff;
   logic        [WW-1:0] direct5_ff;
   iva_pkg::ctrl_type    ctrl5_ff;

   logic signed [OW-1:0] diff, one_minus_w;
   logic        [WW-1:0] s0, s1;

   // operand selection and the simple component results
   always_comb begin
      diff        = {b[WW-1], b} - {a[WW-1], a};
      one_minus_w = iva_pkg::ONE_FX - {w[WW-1], w};
      m0a_in      = '0;
      m0b_in      = '0;
      m1a_in      = '0;
      m1b_in      = '0;
      if (ctrl.is_dot) begin
         m0a_in = {a[WW-1], a};
         m0b_in = {b[WW-1], b};
      end else if (ctrl.is_cross) begin
         m0a_in = {cross_a0[WW-1], cross_a0};
         m0b_in = {cross_b0[WW-1], cross_b0};
         m1a_in = {cross_a1[WW-1], cross_a1};
         m1b_in = {cross_b1[WW-1], cross_b1};
      end else if (ctrl.is_scale) begin
         m0a_in = {a[WW-1], a};
         m0b_in = {w[WW-1], w};
      end else if (ctrl.is_lerp) begin
         m0a_in = diff;
         m0b_in = {w[WW-1], w};
      end else if (ctrl.is_interp) begin
         m0a_in = {a[WW-1], a};
         m0b_in = {w[WW-1], w};
         m1a_in = {b[WW-1], b};
         m1b_in = one_minus_w;
      end
      direct2_in = '0;
      if (ctrl.is_add) begin
         direct2_in = a + b;
      end else if (ctrl.is_sub) begin
         direct2_in = a - b;
      end else if (ctrl.is_min) begin
         direct2_in = (a < b) ? a : b;
      end else if (ctrl.is_max) begin
         direct2_in = (a > b) ? a : b;
      end
   end

   // full signed products
   always_comb begin
      p0_in = m0a_ff * m0b_ff;
      p1_in = m1a_ff * m1b_ff;
   end

   // lerp adds a scaled up, cross takes the wrapped difference
   always_comb begin
      lerp_off   = ctrl3_ff.is_lerp ? (NW'(a3_ff) <<< iva_pkg::FRAC_BITS) : NW'(0);
      n0_in      = NW'(p0_ff) + lerp_off;
      n1_in      = NW'(p1_ff);
      direct4_in = ctrl3_ff.is_cross ? (p0_ff[WW-1:0] - p1_ff[WW-1:0]) : direct3_ff;
   end

   // truncate toward zero
   always_comb begin
      q0_in = iva_pkg::trunc_div(n0_ff);
      q1_in = iva_pkg::trunc_div(n1_ff);
   end

   // pipeline registers, payload only
   always_ff @(posedge clock) begin
      m0a_ff     <= m0a_in;
      m0b_ff     <= m0b_in;
      m1a_ff     <= m1a_in;
      m1b_ff     <= m1b_in;
      direct2_ff <= direct2_in;
      a2_ff      <= a;
      ctrl2_ff   <= ctrl;

      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      direct3_ff <= direct2_ff;
      a3_ff      <= a2_ff;
      ctrl3_ff   <= ctrl2_ff;

      n0_ff      <= n0_in;
      n1_ff      <= n1_in;
      direct4_ff <= direct4_in;
      dot_lo_ff  <= p0_ff[WW-1:0];
      ctrl4_ff   <= ctrl3_ff;

      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
      direct5_ff <= direct4_ff;
      ctrl5_ff   <= ctrl4_ff;
   end

   // saturate and pick the lane result
   always_comb begin
      s0 = iva_pkg::sat_word(q0_ff);
      s1 = iva_pkg::sat_word(q1_ff);
      if (ctrl5_ff.is_interp) begin
         result = s0 + s1;
      end else if (ctrl5_ff.is_scale || ctrl5_ff.is_lerp) begin
         result = s0;
      end else begin
         result = direct5_ff;
      end
   end

   assign dot_lo = dot_lo_ff;

endmodule

// ===== rtl/core/int_vec3_alu.sv =====
`timescale 1ns / 1ps
// top level of the pipelined integer 3-vector alu
//
//   channel   ports                      transfer when
//   request   start, busy, req_data      start high and busy low at a rising edge
//   response  rsp_strobe, rsp_data       rsp_strobe high at a rising edge
//
// one request per cycle, every cycle; busy is always low
// each result passes through the six register stages around the 33 x 33 multipliers
// and the truncate and saturate steps
// synchronous reset clears only the valid bits, payload registers are not reset
// the response side has no back-pressure, so the pipeline never stalls
module int_vec3_alu (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  iva_pkg::req_type req_data,
   output logic             rsp_strobe,
   output iva_pkg::rsp_type rsp_data
);

   localparam int WW = iva_pkg::WORD_W;

   // stage 1 input register
   iva_pkg::req_type  in_ff;
   iva_pkg::ctrl_type ctrl1;

   // valid bits and dot flags travelling alongside the lanes
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in;
   logic dot2_ff, dot3_ff, dot4_ff;

   logic [WW-1:0] scalar5_in, scalar5_ff;
   logic [WW-1:0] lo_x, lo_y, lo_z;
   logic [WW-1:0] res_x, res_y, res_z;

   iva_pkg::rsp_type rsp_in, rsp_ff;
   logic             strobe_ff;

   assign busy  = 1'b0;
   assign v1_in = start && !busy;
   assign ctrl1 = iva_pkg::decode_action(in_ff.action);

   // component lanes, cross operands wired per axis
   iva_lane u_lane_x (
      .clock    (clock),
      .ctrl     (ctrl1),
      .a        (in_ff.ax),
      .b        (in_ff.bx),
      .w        (in_ff.weight),
      .cross_a0 (in_ff.ay),
      .cross_b0 (in_ff.bz),
      .cross_a1 (in_ff.az),
      .cross_b1 (in_ff.by),
      .dot_lo   (lo_x),
      .result   (res_x)
   );

   iva_lane u_lane_y (
      .clock    (clock),
      .ctrl     (ctrl1),
      .a        (in_ff.ay),
      .b        (in_ff.by),
      .w        (in_ff.weight),
      .cross_a0 (in_ff.az),
      .cross_b0 (in_ff.bx),
      .cross_a1 (in_ff.ax),
      .cross_b1 (in_ff.bz),
      .dot_lo   (lo_y),
      .result   (res_y)
   );

   iva_lane u_lane_z (
      .clock    (clock),
      .ctrl     (ctrl1),
      .a        (in_ff.az),
      .b        (in_ff.bz),
      .w        (in_ff.weight),
      .cross_a0 (in_ff.ax),
      .cross_b0 (in_ff.by),
      .cross_a1 (in_ff.ay),
      .cross_b1 (in_ff.bx),
      .dot_lo   (lo_z),
      .result   (res_z)
   );

   // wrapped dot product sum
   assign scalar5_in = dot4_ff ? (lo_x + lo_y + lo_z) : '0;

   // response assembly
   always_comb begin
      rsp_in.rx     = res_x;
      rsp_in.ry     = res_y;
      rsp_in.rz     = res_z;
      rsp_in.scalar = scalar5_ff;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= v1_in;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         strobe_ff <= v5_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff      <= req_data;
      dot2_ff    <= ctrl1.is_dot;
      dot3_ff    <= dot2_ff;
      dot4_ff    <= dot3_ff;
      scalar5_ff <= scalar5_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // every transfer in comes out as a response strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_strobe)
      else $error("request transfer produced no response");

   // a nonzero scalar only comes with a zero vector
   a_dot_vector_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.scalar != 0)) |->
         ((rsp_data.rx == 0) && (rsp_data.ry == 0) && (rsp_data.rz == 0)))
      else $error("dot result carries a nonzero vector");

   // unused codes give an all-zero response
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(start && (req_data.action > iva_pkg::ACT_INTERP), 6)) |->
         ((rsp_data.rx == 0) && (rsp_data.ry == 0) && (rsp_data.rz == 0) &&
          (rsp_data.scalar == 0)))
      else $error("unused action code gave a nonzero response");

endmodule

// ===== test/int_vec3_alu_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the integer 3-vector alu: directed corners, then random traffic
module int_vec3_alu_tb;

   // codes outside the operation set, expected to give all-zero results
   localparam logic [3:0] ACT_SPARE_LO = 4'd9;
   localparam logic [3:0] ACT_SPARE_HI = 4'd15;

   localparam logic [31:0] WORD_MAX   = iva_pkg::SAT_MAX;
   localparam logic [31:0] WORD_MIN   = iva_pkg::SAT_MIN;
   localparam logic [31:0] WEIGHT_ONE = 32'(1 << iva_pkg::FRAC_BITS);

   // wide signed arithmetic for the fixed-point predictions
   localparam logic signed [95:0] ONE_WIDE = 96'sd1 << iva_pkg::FRAC_BITS;
   localparam logic signed [95:0] HI_WIDE  = 96'sd2147483647;
   localparam logic signed [95:0] LO_WIDE  = -96'sd2147483648;

   localparam int RANDOM_OPS   = 1850;
   localparam int SETTLE_TICKS = 20;

   typedef struct {
      iva_pkg::req_type op;
      int unsigned      gap;
      bit               drain;
   } op_entry_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   iva_pkg::req_type req_data   = '0;
   logic             busy;
   logic             rsp_strobe;
   iva_pkg::rsp_type rsp_data;

   op_entry_type     queued_ops[$];
   iva_pkg::rsp_type predicted_results[$];
   int unsigned      transfers_in  = 0;
   int unsigned      transfers_out = 0;
   int unsigned      idle_cycles   = 0;
   int               error_count   = 0;

   int_vec3_alu dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("int_vec3_alu regression: fail");
      $finish;
   end

   // divide by one in the weight format toward zero, then clamp to 32 bits
   function automatic logic [31:0] fixed_to_word(input logic signed [95:0] n);
      logic signed [95:0] q;
      q = n / ONE_WIDE;
      if (q > HI_WIDE) return WORD_MAX;
      if (q < LO_WIDE) return WORD_MIN;
      return q[31:0];
   endfunction

   function automatic logic [31:0] scale_fixed(input logic signed [95:0] x,
                                               input logic signed [95:0] f);
      return fixed_to_word(x * f);
   endfunction

   // expected result of one operation
   function automatic iva_pkg::rsp_type alu_result(input iva_pkg::req_type op);
      logic signed [31:0] av [3];
      logic signed [31:0] bv [3];
      logic signed [31:0] wv;
      logic signed [95:0] aw, bw, ww;
      logic [31:0]        rv [3];
      logic [31:0]        dot_sum;
      iva_pkg::rsp_type   r;
      av[0] = op.ax; av[1] = op.ay; av[2] = op.az;
      bv[0] = op.bx; bv[1] = op.by; bv[2] = op.bz;
      wv = op.weight;
      ww = wv;
      dot_sum = '0;
      for (int i = 0; i < 3; i++) begin
         rv[i] = '0;
         aw = av[i];
         bw = bv[i];
         case (op.action)
            iva_pkg::ACT_ADD:    rv[i] = av[i] + bv[i];
            iva_pkg::ACT_SUB:    rv[i] = av[i] - bv[i];
            iva_pkg::ACT_MIN:    rv[i] = (av[i] < bv[i]) ? av[i] : bv[i];
            iva_pkg::ACT_MAX:    rv[i] = (av[i] > bv[i]) ? av[i] : bv[i];
            iva_pkg::ACT_DOT:    dot_sum = dot_sum + av[i] * bv[i];
            iva_pkg::ACT_CROSS:  rv[i] = av[(i + 1) % 3] * bv[(i + 2) % 3]
                                       - av[(i + 2) % 3] * bv[(i + 1) % 3];
            iva_pkg::ACT_SCALE:  rv[i] = scale_fixed(aw, ww);
            // the whole sum is truncated once
            iva_pkg::ACT_LERP:   rv[i] = fixed_to_word(aw * ONE_WIDE + (bw - aw) * ww);
            // each term clamps on its own, the sum wraps
            iva_pkg::ACT_INTERP: rv[i] = scale_fixed(aw, ww) +
                                         scale_fixed(bw, ONE_WIDE - ww);
            default:             rv[i] = '0;
         endcase
      end
      r.rx     = rv[0];
      r.ry     = rv[1];
      r.rz     = rv[2];
      r.scalar = dot_sum;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] wanted,
                                       input logic [31:0] seen);
      if (wanted !== seen) begin
         $error("%s mismatch: expected %0d, actual %0d", field,
                $signed(wanted), $signed(seen));
         error_count++;
      end
   endfunction

   task automatic queue_op(input logic [3:0] action,
                           input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] az, input logic [31:0] bx,
                           input logic [31:0] by, input logic [31:0] bz,
                           input logic [31:0] weight, input int unsigned gap,
                           input bit drain);
      op_entry_type e;
      e.op.action = action;
      e.op.ax     = ax;
      e.op.ay     = ay;
      e.op.az     = az;
      e.op.bx     = bx;
      e.op.by     = by;
      e.op.bz     = bz;
      e.op.weight = weight;
      e.gap       = gap;
      e.drain     = drain;
      queued_ops.push_back(e);
   endtask

   // operand mix weighted toward extremes and small values
   function automatic logic [31:0] random_word();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = WORD_MIN;
         1:       v = WORD_MAX;
         2:       v = 32'($urandom_range(0, 2)) - 32'd1;
         3, 4:    v = 32'(int'($urandom_range(0, 2000)) - 1000);
         5:       begin
                     v = 32'd1 << $urandom_range(0, 31);
                     if ($urandom_range(0, 1)) v = -v;
                  end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // weights: exact one, zero, tiny fractions, within two, near one, extremes and full range
   function automatic logic [31:0] random_weight();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = WEIGHT_ONE;
         1:       v = '0;
         2:       v = 32'(int'($urandom_range(0, 64)) - 32);
         3, 4:    v = 32'(int'($urandom_range(0, 4 * (1 << iva_pkg::FRAC_BITS))) -
                          2 * (1 << iva_pkg::FRAC_BITS));
         5:       v = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
         6:       v = WEIGHT_ONE + 32'(int'($urandom_range(0, 200)) - 100);
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // driver: one queued operation per transfer, with its idle gap and optional drain
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_cycles = 0;
      end else if (!(start && busy)) begin
         if (queued_ops.size() == 0) begin
            start <= 1'b0;
         end else if (idle_cycles < queued_ops[0].gap) begin
            idle_cycles++;
            start <= 1'b0;
         end else if (queued_ops[0].drain &&
                      transfers_in + (start ? 1 : 0) != transfers_out) begin
            start <= 1'b0;
         end else begin
            req_data <= queued_ops[0].op;
            start    <= 1'b1;
            void'(queued_ops.pop_front());
            idle_cycles = 0;
         end
      end
   end

   // monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      iva_pkg::rsp_type wanted;
      if (!reset) begin
         if (start && !busy) begin
            predicted_results.push_back(alu_result(req_data));
            transfers_in <= transfers_in + 1;
         end
         if (rsp_strobe) begin
            transfers_out <= transfers_out + 1;
            if (predicted_results.size() == 0) begin
               $error("result with no request outstanding");
               error_count++;
            end else begin
               wanted = predicted_results.pop_front();
               check_field("rx", wanted.rx, rsp_data.rx);
               check_field("ry", wanted.ry, rsp_data.ry);
               check_field("rz", wanted.rz, rsp_data.rz);
               check_field("scalar", wanted.scalar, rsp_data.scalar);
            end
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      logic [3:0]  action;
      int unsigned gap_mode;
      int unsigned gap;
      logic [31:0] half;
      half = WEIGHT_ONE >> 1;

      // directed corners: wrap, signed compares, truncation, clamping, spare codes
      queue_op(iva_pkg::ACT_ADD, WORD_MAX, WORD_MIN, 32'hffff_ffff, WORD_MAX, WORD_MIN,
               32'd1, '0, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_SUB, WORD_MIN, WORD_MAX, '0, 32'd1, 32'hffff_ffff, WORD_MIN,
               '0, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_MIN, WORD_MIN, 32'hffff_ffff, WORD_MAX, WORD_MAX, 32'd1,
               WORD_MIN, '0, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_MAX, WORD_MIN, 32'hffff_ffff, WORD_MAX, WORD_MAX, 32'd1,
               WORD_MIN, '0, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_DOT, WORD_MIN, WORD_MAX, 32'hffff_ffff, WORD_MIN, WORD_MAX,
               32'd3, WEIGHT_ONE, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_CROSS, WORD_MAX, WORD_MIN, 32'd7, 32'hffff_fffe, WORD_MAX,
               WORD_MIN, WEIGHT_ONE, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_SCALE, WORD_MAX, WORD_MIN, 32'hffff_fff9, '0, '0, '0,
               WEIGHT_ONE, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_SCALE, 32'd5, 32'hffff_fffb, 32'd65537, '0, '0, '0,
               32'hffff_ffff, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_SCALE, WORD_MAX, WORD_MIN, 32'hffff_ffff, '0, '0, '0,
               WORD_MAX, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_SCALE, WORD_MIN, WORD_MAX, 32'd1, '0, '0, '0,
               WORD_MIN, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_LERP, WORD_MIN, WORD_MAX, 32'd9, WORD_MAX, WORD_MIN,
               32'hffff_fff7, '0, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_LERP, WORD_MIN, WORD_MAX, 32'd9, WORD_MAX, WORD_MIN,
               32'hffff_fff7, WEIGHT_ONE, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_LERP, WORD_MIN, WORD_MAX, '0, WORD_MAX, WORD_MIN, 32'd1,
               WORD_MAX, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_LERP, WORD_MIN, WORD_MAX, '0, WORD_MAX, WORD_MIN, 32'd1,
               WORD_MIN, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_LERP, 32'd3, 32'hffff_fffd, 32'd4, '0, 32'd2, 32'hffff_fffb,
               half, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_INTERP, WORD_MAX, WORD_MIN, 32'd11, WORD_MIN, WORD_MAX,
               32'hffff_fff5, '0, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_INTERP, WORD_MAX, WORD_MIN, 32'd11, WORD_MIN, WORD_MAX,
               32'hffff_fff5, WEIGHT_ONE, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_INTERP, WORD_MAX, WORD_MIN, 32'd11, WORD_MIN, WORD_MAX,
               32'hffff_fff5, WORD_MIN, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_INTERP, WORD_MIN, WORD_MAX, 32'd1, WORD_MAX, WORD_MIN,
               32'hffff_ffff, WORD_MAX, $urandom_range(0, 11), 1'b0);
      queue_op(ACT_SPARE_LO, WORD_MAX, WORD_MIN, 32'd1, WORD_MAX, WORD_MIN, 32'd1,
               WEIGHT_ONE, $urandom_range(0, 11), 1'b0);
      queue_op(ACT_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_INTERP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               $urandom_range(0, 11), 1'b0);
      queue_op(iva_pkg::ACT_DOT, '0, '0, '0, '0, '0, '0, '0, 0, 1'b0);

      // random traffic in runs of back-to-back, sparse and fully random gaps
      gap_mode = 0;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 64 == 0) gap_mode = $urandom_range(0, 2);
         case (gap_mode)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 11);
            default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
         endcase
         if ($urandom_range(0, 99) < 92) begin
            action = 4'($urandom_range(iva_pkg::ACT_ADD, iva_pkg::ACT_INTERP));
         end else begin
            action = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         end
         queue_op(action, random_word(), random_word(), random_word(), random_word(),
                  random_word(), random_word(), random_weight(), gap, n % 600 == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for every request transfer, then for every result
      while (queued_ops.size() != 0 || start) @(negedge clock);
      while (predicted_results.size() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);

      if (predicted_results.size() != 0) begin
         $error("%0d results never arrived", predicted_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("int_vec3_alu regression: pass");
      end else begin
         $display("int_vec3_alu regression: fail");
      end
      $finish;
   end

endmodule
